[rtl/core/assert_macros.svh]
// Assertion macros used by the nlp_checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/nlp_pkg.sv]
// ----------------------------------------------------------------------------
// nlp_pkg
// Shared widths, constants and cell types for the negative-log prox core.
// ----------------------------------------------------------------------------
package nlp_pkg;

    localparam int unsigned DATA_W       = 32;
    localparam int unsigned RAD_W        = 64;
    localparam int unsigned ROOT_W       = 32;
    localparam int unsigned WEIGHT_SHIFT = 18;
    localparam logic [31:0] WEIGHT_RESET = 32'h0001_0000;

    typedef struct packed {
        logic              valid;
        logic [RAD_W-1:0]  rem;
        logic [RAD_W-1:0]  rad;
        logic [ROOT_W-1:0] root;
        logic [DATA_W-1:0] mag;
        logic              neg;
    } nlp_cell_t;

endpackage

[rtl/core/nlp_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// nlp_sqrt_cell
// One restoring square-root digit step; settles one root bit per beat.
// ----------------------------------------------------------------------------
module nlp_sqrt_cell #(
    parameter int unsigned STEP = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  nlp_pkg::nlp_cell_t cell_in,
    output nlp_pkg::nlp_cell_t cell_out
);

    localparam int unsigned SH = nlp_pkg::RAD_W - 2 * (STEP + 1);

    nlp_pkg::nlp_cell_t cell_reg;
    nlp_pkg::nlp_cell_t cell_next;
    logic [nlp_pkg::RAD_W-1:0] rem_sh;
    logic [nlp_pkg::RAD_W-1:0] trial;
    logic [nlp_pkg::RAD_W-1:0] pair;

    always_comb begin
        pair   = (cell_in.rad >> SH) & 64'd3;
        rem_sh = {cell_in.rem[nlp_pkg::RAD_W-3:0], 2'b00} | pair;
        trial  = {{(nlp_pkg::RAD_W-nlp_pkg::ROOT_W-2){1'b0}}, cell_in.root, 2'b01};
        cell_next = cell_in;
        if (rem_sh >= trial) begin
            cell_next.rem  = rem_sh - trial;
            cell_next.root = {cell_in.root[nlp_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            cell_next.rem  = rem_sh;
            cell_next.root = {cell_in.root[nlp_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (advance) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

[rtl/core/negative_log_prox_elementwise_core.sv]
// ----------------------------------------------------------------------------
// negative_log_prox_elementwise_core
// Prox of lambda * (-log x) on a stream of signed Q16.16 elements.
// ----------------------------------------------------------------------------
// Accepts one element per cycle while the output is not stalled and returns
// one unsigned Q16.16 result per element, in order, floor((v + sqrt(v^2 +
// 4 lambda)) / 2), via one square stage, a row of 32 square-root digit cells
// and one output stage. The whole row stalls while the output beat is held.
module negative_log_prox_elementwise_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [31:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_prox_value
);

    localparam int unsigned N = nlp_pkg::ROOT_W;

    logic [31:0] weight_reg;
    logic        advance;
    nlp_pkg::nlp_cell_t head_reg;
    nlp_pkg::nlp_cell_t chain [0:N];
    logic [31:0] mag;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic [32:0] sum;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = advance;
    assign mag = s_value[31] ? (~s_value + 32'd1) : s_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= nlp_pkg::WEIGHT_RESET;
        end else if (cfg_wr_en) begin
            weight_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg.valid <= 1'b0;
        end else if (advance) begin
            head_reg.valid <= s_valid;
            head_reg.rad   <= 64'(mag) * 64'(mag)
                            + (64'(weight_reg) << nlp_pkg::WEIGHT_SHIFT);
            head_reg.rem   <= '0;
            head_reg.root  <= '0;
            head_reg.mag   <= mag;
            head_reg.neg   <= s_value[31];
        end
    end

    assign chain[0] = head_reg;

    for (genvar i = 0; i < N; i++) begin : g_cell
        nlp_sqrt_cell #(.STEP(i)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .cell_in (chain[i]),
            .cell_out(chain[i+1])
        );
    end

    assign sum = chain[N].neg ? ({1'b0, chain[N].root} - {1'b0, chain[N].mag})
                              : ({1'b0, chain[N].root} + {1'b0, chain[N].mag});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= chain[N].valid;
            out_data_reg  <= sum[32:1];
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_prox_value = out_data_reg;

endmodule

[rtl/core/nlp_checker.sv]
// ----------------------------------------------------------------------------
// nlp_checker
// Port-level checks for the negative-log prox core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nlp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_prox_value
);

    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_prox_value), "output beat dropped or changed while stalled")
    `ASSERT_CLK(a_ready_free, aclk, aresetn, !m_valid |-> s_ready, "input blocked with no output pending")
    `ASSERT_CLK(a_ready_stall, aclk, aresetn, m_valid && !m_ready |-> !s_ready, "input taken while pipe stalled")
    `ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_valid, "output valid right after reset")

endmodule

bind negative_log_prox_elementwise_core nlp_checker u_nlp_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_prox_value(m_prox_value)
);

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Streams signed Q16.16 elements through the negative-log prox core under
// several weights, predicts each root with an integer square root and checks
// every output beat in order, with random bursts and output stalls.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 34;
    localparam int MAX_CYCLE = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic signed [31:0] s_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_prox_value;

    logic [31:0] weight_q = nlp_pkg::WEIGHT_RESET;
    logic [31:0] prox_expected_q[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    logic        stall_mode = 1'b0;

    negative_log_prox_elementwise_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_value(s_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_prox_value(m_prox_value)
    );

    always #5 aclk = ~aclk;

    function automatic logic [63:0] int_sqrt(input logic [63:0] rad);
        logic [63:0] root;
        logic [63:0] bitv;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > rad) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rad >= root + bitv) begin
                rad  = rad - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [31:0] prox_point(input logic [31:0] v, input logic [31:0] lam);
        logic [63:0] mag;
        logic [63:0] root;
        logic [63:0] sum;
        mag  = v[31] ? {32'd0, -v} : {32'd0, v};
        root = int_sqrt(mag * mag + ({32'd0, lam} << nlp_pkg::WEIGHT_SHIFT));
        sum  = v[31] ? root - mag : root + mag;
        sum  = sum >> 1;
        return (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // receiver stall pattern: alternate between always-ready and random stalls
    always @(posedge aclk) begin
        if (($urandom & 63) == 0) stall_mode <= ~stall_mode;
        m_ready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (prox_expected_q.size() == 0) begin
                $display("%0t: unexpected beat, actual %h", $time, m_prox_value);
                error_count++;
            end else begin
                logic [31:0] exp_v;
                exp_v = prox_expected_q.pop_front();
                if (m_prox_value !== exp_v) begin
                    $display("%0t: prox_value expected %h actual %h",
                             $time, exp_v, m_prox_value);
                    error_count++;
                end
            end
        end
    end

    // hold valid across back-to-back beats; drop it only for a gap or a drain
    task automatic send_value(input logic [31:0] v);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_value <= v;
        prox_expected_q.push_back(prox_point(v, weight_q));
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (prox_expected_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic set_weight(input logic [31:0] w);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        weight_q = w;
    endtask

    task automatic test_directed();
        logic [31:0] vals[14];
        vals = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'hFFFE_0000,
                 32'h0000_8000, 32'hFFFF_8000, 32'h4000_0000, 32'hC000_0000,
                 32'h8000_0001};
        foreach (vals[i]) send_value(vals[i]);
    endtask

    task automatic test_zero_weight();
        set_weight(32'h0);
        send_value(32'h0);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(32'hFFFF_FFFF);
        send_value(32'h0000_0001);
    endtask

    task automatic test_random(input int n);
        logic [31:0] v;
        repeat (n) begin
            case ($urandom_range(0, 3))
                0: v = $urandom;
                1: v = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
                2: v = {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
                default: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 99)
                                                   : 32'h8000_0000 + $urandom_range(0, 99);
            endcase
            send_value(v);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(250);
        test_zero_weight();
        set_weight(32'hFFFF_FFFF);
        test_directed();
        test_random(250);
        set_weight(32'h0000_0001);
        test_random(200);
        set_weight($urandom);
        test_random(200);
        set_weight(32'h0000_4000);
        test_random(100);
        drain();
        if (error_count == 0 && prox_expected_q.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule
